@@ rtl/afd_pkg.sv @@
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants for the alternating flap drive.
// ----------------------------------------------------------------------------
package afd_pkg;

  // field widths
  localparam int PeriodW = 16;
  localparam int HalfW   = PeriodW - 1;
  localparam int PctW    = 7;
  localparam int LevelW  = 8;
  localparam int WinW    = HalfW + PctW;
  localparam int FlapsW  = 16;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;

  // arithmetic constants
  localparam int unsigned Percent   = 100;
  localparam int unsigned FullLevel = 255;

  // reciprocal of 100 for a 15-bit dividend: floor(x * LevelRecip >> LevelShift)
  localparam int unsigned LevelRecip = 41944;
  localparam int          LevelShift = 22;
  localparam int          DutyProdW  = PctW + LevelW;
  localparam int          RecipProdW = DutyProdW + 16;

  // reset values of the registers
  localparam logic [PctW-1:0]    DutyReset   = PctW'(100);
  localparam logic [PeriodW-1:0] PeriodReset = PeriodW'(2000);

  // drive modes; the unused code behaves as flap
  typedef enum logic [1:0] {
    MODE_FLAP  = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_RIGHT = 2'd2
  } mode_e;

  // register map, word index
  typedef enum logic [2:0] {
    REG_DRIVE_MODE = 3'd0,
    REG_DUTY       = 3'd1,
    REG_DEAD_ZONE  = 3'd2,
    REG_PWM_EN     = 3'd3,
    REG_PERIOD     = 3'd4
  } reg_e;

  // settings handed from the register block to the drive core
  typedef struct packed {
    logic [1:0]        mode;
    logic              pwm_en;
    logic [HalfW-1:0]  half;
    logic [WinW-1:0]   win_x;
    logic [LevelW-1:0] level;
  } drv_cfg_t;

endpackage

@@ rtl/afd_cfg.sv @@
// ----------------------------------------------------------------------------
// afd_cfg
// APB register block with precomputed half period, window bound and level.
// ----------------------------------------------------------------------------
module afd_cfg import afd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output drv_cfg_t         cfg_o
);

  logic [1:0]         mode_q;
  logic [PctW-1:0]    duty_q;
  logic [PctW-1:0]    dz_q;
  logic               pwm_q;
  logic [PeriodW-1:0] period_q;

  logic               wr;
  logic [2:0]         idx;

  logic [PctW-1:0]       dz_sat;
  logic [PctW-1:0]       active_pct;
  logic [WinW-1:0]       win_d, win_q;
  logic [HalfW-1:0]      half_d, half_q;
  logic [DutyProdW-1:0]  duty_x255;
  logic [RecipProdW-1:0] lvl_prod;
  logic [LevelW:0]       lvl_raw;
  logic [LevelW-1:0]     level_d, level_q;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[4:2];

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_FLAP;
      duty_q   <= DutyReset;
      dz_q     <= '0;
      pwm_q    <= 1'b0;
      period_q <= PeriodReset;
    end else if (wr) begin
      unique case (idx)
        REG_DRIVE_MODE: mode_q   <= pwdata[1:0];
        REG_DUTY:       duty_q   <= pwdata[PctW-1:0];
        REG_DEAD_ZONE:  dz_q     <= pwdata[PctW-1:0];
        REG_PWM_EN:     pwm_q    <= pwdata[0];
        REG_PERIOD:     period_q <= pwdata[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (idx)
      REG_DRIVE_MODE: prdata = DataW'(mode_q);
      REG_DUTY:       prdata = DataW'(duty_q);
      REG_DEAD_ZONE:  prdata = DataW'(dz_q);
      REG_PWM_EN:     prdata = DataW'(pwm_q);
      REG_PERIOD:     prdata = DataW'(period_q);
      default:        prdata = '0;
    endcase
  end

  // window bound scaled by 100: half * (100 - dead zone)
  assign dz_sat     = (dz_q > PctW'(Percent)) ? PctW'(Percent) : dz_q;
  assign active_pct = PctW'(Percent) - dz_sat;
  assign half_d     = period_q[PeriodW-1:1];
  assign win_d      = WinW'(half_d) * WinW'(active_pct);

  // pwm level 255 * duty / 100 by reciprocal, saturated at full level
  assign duty_x255 = {duty_q, LevelW'(0)} - DutyProdW'(duty_q);
  assign lvl_prod  = RecipProdW'(duty_x255) * RecipProdW'(LevelRecip);
  assign lvl_raw   = lvl_prod[LevelShift +: (LevelW + 1)];
  assign level_d   = (lvl_raw > (LevelW + 1)'(FullLevel)) ? LevelW'(FullLevel)
                                                          : lvl_raw[LevelW-1:0];

  // derived settings, registered from the written registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q  <= HalfW'(1000);
      win_q   <= WinW'(100000);
      level_q <= LevelW'(FullLevel);
    end else begin
      half_q  <= half_d;
      win_q   <= win_d;
      level_q <= level_d;
    end
  end

  assign cfg_o.mode   = mode_q;
  assign cfg_o.pwm_en = pwm_q;
  assign cfg_o.half   = half_q;
  assign cfg_o.win_x  = win_q;
  assign cfg_o.level  = level_q;

endmodule

@@ rtl/afd_core.sv @@
// ----------------------------------------------------------------------------
// afd_core
// Input register, flap timing state and result register of the drive.
// ----------------------------------------------------------------------------
module afd_core import afd_pkg::*; #(
  parameter int TIME_WIDTH  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drv_cfg_t          cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              tick_i,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              drive_right_o,
  output logic              drive_left_o,
  output logic [LevelW-1:0] pwm_level_o,
  output logic              led_on_o,
  output logic              moving_right_o,
  output logic [FlapsW-1:0] flaps_done_o
);

  localparam int CmpW = (TIME_WIDTH > HalfW) ? TIME_WIDTH : HalfW;
  localparam int MulW = ((TIME_WIDTH + PctW) > WinW) ? (TIME_WIDTH + PctW) : WinW;

  // input stage
  logic in_vld_q, tick_q, restart_q;
  logic adv;

  // timing state
  logic [TIME_WIDTH-1:0]  elapsed_q, elapsed_d;
  logic                   dir_q, dir_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   led_q, led_d;

  // intermediate values
  logic [TIME_WIDTH-1:0]  el_tick;
  logic [TIME_WIDTH-1:0]  el_mode;
  logic                   dir_mode;
  logic [COUNT_WIDTH-1:0] cnt_start;
  logic                   flip;
  logic [MulW-1:0]        el_x100;
  logic                   active;
  logic                   right_d, left_d;
  logic [LevelW-1:0]      pwm_d;

  // result stage
  logic out_vld_q;

  assign adv        = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      tick_q    <= tick_i;
      restart_q <= restart_i;
    end
  end

  // restart and saturating time advance
  assign cnt_start = restart_q ? COUNT_WIDTH'(1) : count_q;
  assign el_tick   = (tick_q && (elapsed_q != '1)) ? elapsed_q + TIME_WIDTH'(1) : elapsed_q;

  // fixed-side modes pin the time and the direction
  always_comb begin
    case (cfg_i.mode)
      MODE_LEFT: begin
        el_mode  = '0;
        dir_mode = 1'b0;
      end
      MODE_RIGHT: begin
        el_mode  = '0;
        dir_mode = 1'b1;
      end
      default: begin
        el_mode  = el_tick;
        dir_mode = dir_q;
      end
    endcase
  end

  // half-period reversal
  assign flip      = CmpW'(el_mode) >= CmpW'(cfg_i.half);
  assign elapsed_d = flip ? '0 : el_mode;
  assign dir_d     = flip ? ~dir_mode : dir_mode;
  assign count_d   = flip ? cnt_start + COUNT_WIDTH'(1) : cnt_start;

  // active window: elapsed * 100 <= half * (100 - dead zone)
  assign el_x100 = MulW'(elapsed_d) * MulW'(Percent);
  assign active  = el_x100 <= MulW'(cfg_i.win_x);

  // side outputs and lamp
  always_comb begin
    right_d = 1'b0;
    left_d  = 1'b0;
    pwm_d   = '0;
    led_d   = led_q;
    if (active) begin
      pwm_d   = cfg_i.pwm_en ? cfg_i.level : '0;
      right_d = dir_d;
      left_d  = ~dir_d;
      led_d   = dir_d;
    end
  end

  // state update per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q <= '0;
      dir_q     <= 1'b1;
      count_q   <= COUNT_WIDTH'(1);
      led_q     <= 1'b0;
    end else if (adv) begin
      elapsed_q <= elapsed_d;
      dir_q     <= dir_d;
      count_q   <= count_d;
      led_q     <= led_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      drive_right_o  <= right_d;
      drive_left_o   <= left_d;
      pwm_level_o    <= pwm_d;
      led_on_o       <= led_d;
      moving_right_o <= dir_d;
      flaps_done_o   <= FlapsW'(count_d);
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

@@ rtl/alternating_flap_drive.sv @@
// An accepted transaction goes through the input register, then the result register.
// Throughput: one transaction per cycle unless out_ready_i stalls the result register.
// Register writes reach the drive logic through the settings registers.
// Reset: time 0, direction right, flap count 1, lamp off, registers at their defaults.
// ----------------------------------------------------------------------------
// alternating_flap_drive
// Two-sided actuator drive with alternating direction, dead zone and pwm level.
// ----------------------------------------------------------------------------
module alternating_flap_drive import afd_pkg::*; #(
  parameter int TIME_WIDTH  = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              tick_i,
  input  logic              restart_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              drive_right_o,
  output logic              drive_left_o,
  output logic [LevelW-1:0] pwm_level_o,
  output logic              led_on_o,
  output logic              moving_right_o,
  output logic [FlapsW-1:0] flaps_done_o
);

  drv_cfg_t cfg;

  // register block
  afd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // drive core
  afd_core #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .tick_i         (tick_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .drive_right_o  (drive_right_o),
    .drive_left_o   (drive_left_o),
    .pwm_level_o    (pwm_level_o),
    .led_on_o       (led_on_o),
    .moving_right_o (moving_right_o),
    .flaps_done_o   (flaps_done_o)
  );

endmodule

@@ dv/alternating_flap_drive_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alternating_flap_drive_tb
// Self-checking bench for the flap drive. A directed table covers the reset
// state and each corner of the drive rules. A short run at a zero half period
// reverses on every transaction. Random register settings with random tick and
// restart traffic follow. Every result is checked against a local model of the
// drive or against a result given in the table.
// ----------------------------------------------------------------------------
module alternating_flap_drive_tb;
  import afd_pkg::*;

  localparam int          ClkPeriod     = 10;
  localparam int          TimeoutNs     = 30_000_000;
  localparam int          ZeroHalfItems = 40;
  localparam int          NumPhases     = 8;
  localparam int          PhaseItems    = 150;
  localparam logic [1:0]  ModeUnused    = 2'd3;

  // one result of the drive, in port order
  typedef struct packed {
    logic              right;
    logic              left;
    logic [LevelW-1:0] pwm;
    logic              led;
    logic              mov;
    logic [FlapsW-1:0] flaps;
  } drive_res_t;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_e;

  // one row of the directed table: a register write or an input transaction
  typedef struct packed {
    row_kind_e  kind;
    reg_e       idx;
    logic [15:0] val;
    logic       tick;
    logic       restart;
    logic       typed;
    drive_res_t res;
  } stim_row_t;

  localparam drive_res_t NoRes      = '0;
  localparam drive_res_t RightStart = '{1'b1, 1'b0, 8'd0, 1'b1, 1'b1, 16'd1};

  localparam int NumRows = 35;
  localparam stim_row_t DirRows [NumRows] = '{
    // reset settings: flap mode, 2000 ms period, no dead zone, pwm off
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b0, 1'b0, 1'b1, RightStart},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b1, 1'b1, RightStart},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b1, RightStart},
    // period 2, half period 1: reverses on every tick
    '{ROW_WRITE, REG_PERIOD,     16'd2,            1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b1, 1'b0, NoRes},
    // pwm with zero duty still drives the side
    '{ROW_WRITE, REG_PWM_EN,     16'd1,            1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_WRITE, REG_DUTY,       16'd0,            1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b0, 1'b0, 1'b0, NoRes},
    // duty above 100 saturates the level
    '{ROW_WRITE, REG_DUTY,       16'd127,          1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b0, 1'b0, 1'b0, NoRes},
    // dead zone above 100, driven only at time zero
    '{ROW_WRITE, REG_DEAD_ZONE,  16'd127,          1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_WRITE, REG_PERIOD,     16'd20,           1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    // unused mode code runs as flap
    '{ROW_WRITE, REG_DRIVE_MODE, 16'(ModeUnused),  1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_WRITE, REG_DEAD_ZONE,  16'd50,           1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    // fixed sides hold time at zero
    '{ROW_WRITE, REG_DRIVE_MODE, 16'(MODE_LEFT),   1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    '{ROW_WRITE, REG_DRIVE_MODE, 16'(MODE_RIGHT),  1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    // zero half period reverses on every item; a fixed side is then always reversed
    '{ROW_WRITE, REG_PERIOD,     16'd0,            1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_WRITE, REG_PERIOD,     16'd1,            1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_WRITE, REG_DRIVE_MODE, 16'(MODE_LEFT),   1'b0, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b1, 1'b0, 1'b0, NoRes},
    '{ROW_ITEM,  REG_DRIVE_MODE, 16'd0,            1'b0, 1'b0, 1'b0, NoRes}
  };

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [DataW-1:0]  pwdata;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              tick_i;
  logic              restart_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              drive_right_o;
  logic              drive_left_o;
  logic [LevelW-1:0] pwm_level_o;
  logic              led_on_o;
  logic              moving_right_o;
  logic [FlapsW-1:0] flaps_done_o;

  // bench control, driven alongside the payload
  logic       idle_on;
  logic       pend_typed;
  drive_res_t pend_res;
  int         stall_cnt = 0;

  // mirror of the drive registers and state
  logic [1:0]         m_mode    = MODE_FLAP;
  logic [PctW-1:0]    m_duty    = DutyReset;
  logic [PctW-1:0]    m_dead    = '0;
  logic               m_pwm     = 1'b0;
  logic [PeriodW-1:0] m_period  = PeriodReset;
  logic [15:0]        m_elapsed = '0;
  logic               m_right   = 1'b1;
  logic [15:0]        m_flaps   = 16'd1;
  logic               m_led     = 1'b0;

  drive_res_t pending_drive_q [$];
  int n_in       = 0;
  int n_checked  = 0;
  int n_bad      = 0;
  int n_settings = 0;

  alternating_flap_drive dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .tick_i        (tick_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .drive_right_o (drive_right_o),
    .drive_left_o  (drive_left_o),
    .pwm_level_o   (pwm_level_o),
    .led_on_o      (led_on_o),
    .moving_right_o(moving_right_o),
    .flaps_done_o  (flaps_done_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // advance the mirrored drive by one transaction and return its outputs
  function automatic drive_res_t next_drive(input logic tk, input logic rs);
    logic [HalfW-1:0] half_ms;
    int unsigned      dz;
    int unsigned      window;
    int unsigned      level;
    drive_res_t       res;
    half_ms = m_period[PeriodW-1:1];
    dz      = (m_dead > Percent) ? Percent : m_dead;
    window  = (half_ms * (Percent - dz)) / Percent;
    level   = (FullLevel * m_duty) / Percent;
    if (level > FullLevel) level = FullLevel;
    res = '0;
    if (rs) m_flaps = 16'd1;
    if (tk && m_elapsed != '1) m_elapsed = m_elapsed + 1'b1;
    if (m_mode == MODE_LEFT) begin
      m_elapsed = '0;
      m_right   = 1'b0;
    end else if (m_mode == MODE_RIGHT) begin
      m_elapsed = '0;
      m_right   = 1'b1;
    end
    // half period over: reverse and count a flap
    if (m_elapsed >= half_ms) begin
      m_right   = ~m_right;
      m_elapsed = '0;
      m_flaps   = m_flaps + 1'b1;
    end
    // active window of the half period
    if (m_elapsed <= window) begin
      res.pwm = m_pwm ? level[LevelW-1:0] : '0;
      if (m_right) begin
        res.right = 1'b1;
        m_led     = 1'b1;
      end else begin
        res.left = 1'b1;
        m_led    = 1'b0;
      end
    end
    res.led   = m_led;
    res.mov   = m_right;
    res.flaps = m_flaps;
    return res;
  endfunction

  // apb write: setup cycle, then access cycle
  task automatic write_reg(input reg_e idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_DRIVE_MODE: m_mode   = val[1:0];
      REG_DUTY:       m_duty   = val[PctW-1:0];
      REG_DEAD_ZONE:  m_dead   = val[PctW-1:0];
      REG_PWM_EN:     m_pwm    = val[0];
      REG_PERIOD:     m_period = val[PeriodW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // offer one transaction, with an optional gap first, and wait for acceptance
  task automatic send_item(input logic tk, input logic rs, input logic typed,
                           input drive_res_t res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    tick_i     <= tk;
    restart_i  <= rs;
    pend_typed <= typed;
    pend_res   <= res;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // stop sending and wait until every expected result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // one full register setting, all five registers
  task automatic apply_setting(input logic [1:0] mode, input logic [PctW-1:0] duty,
                               input logic [PctW-1:0] dead, input logic pwm,
                               input logic [PeriodW-1:0] per);
    wait_drained();
    write_reg(REG_DRIVE_MODE, DataW'(mode));
    write_reg(REG_DUTY,       DataW'(duty));
    write_reg(REG_DEAD_ZONE,  DataW'(dead));
    write_reg(REG_PWM_EN,     DataW'(pwm));
    write_reg(REG_PERIOD,     DataW'(per));
    n_settings++;
  endtask

  // receiver stalls in short bursts
  always @(posedge clk_i) begin
    if (!rst_ni || !idle_on) begin
      out_ready_i <= 1'b1;
    end else if (stall_cnt != 0) begin
      stall_cnt   <= stall_cnt - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_cnt   <= $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // scoreboard: check results, then predict newly accepted transactions
  always @(posedge clk_i) begin : mon
    drive_res_t want;
    drive_res_t got;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{drive_right_o, drive_left_o, pwm_level_o, led_on_o, moving_right_o,
                flaps_done_o};
        if (pending_drive_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("unexpected result transaction at %0t", $realtime);
        end else begin
          want = pending_drive_q.pop_front();
          n_checked++;
          if (got !== want) begin
            n_bad++;
            if (n_bad <= 10) begin
              $display("mismatch #%0d: exp R%b L%b pwm %0d led %b dir %b flaps %0d",
                       n_checked, want.right, want.left, want.pwm, want.led, want.mov,
                       want.flaps);
              $display("  got R%b L%b pwm %0d led %b dir %b flaps %0d",
                       got.right, got.left, got.pwm, got.led, got.mov, got.flaps);
            end
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = next_drive(tick_i, restart_i);
        if (pend_typed) want = pend_res;
        pending_drive_q.push_back(want);
        n_in++;
      end
    end
  end

  // stimulus
  initial begin
    logic [1:0]         mode;
    logic [PctW-1:0]    duty;
    logic [PctW-1:0]    dead;
    logic               pwm;
    logic [PeriodW-1:0] per;
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    tick_i     = 1'b0;
    restart_i  = 1'b0;
    idle_on    = 1'b1;
    pend_typed = 1'b0;
    pend_res   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    for (int i = 0; i < NumRows; i++) begin
      if (DirRows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(DirRows[i].idx, DataW'(DirRows[i].val));
      end else begin
        send_item(DirRows[i].tick, DirRows[i].restart, DirRows[i].typed, DirRows[i].res);
      end
    end

    // zero half period: one flap per transaction
    apply_setting(MODE_FLAP, PctW'(50), '0, 1'b1, '0);
    send_item(1'b1, 1'b1, 1'b0, NoRes);
    for (int k = 1; k < ZeroHalfItems; k++)
      send_item(1'($urandom_range(0, 1)), 1'b0, 1'b0, NoRes);

    // fixed then random settings with random traffic, last phase without idling
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin
          mode = MODE_RIGHT; duty = PctW'(100); dead = PctW'(100); pwm = 1'b1;
          per  = '1;
        end
        1: begin
          mode = MODE_FLAP; duty = '0; dead = '0; pwm = 1'b0; per = PeriodW'(2);
        end
        default: begin
          mode = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(1, 3)) : MODE_FLAP;
          duty = ($urandom_range(0, 3) == 0) ? PctW'($urandom_range(101, 127))
                                             : PctW'($urandom_range(0, 100));
          dead = ($urandom_range(0, 3) == 0) ? PctW'($urandom_range(101, 127))
                                             : PctW'($urandom_range(0, 100));
          pwm  = 1'($urandom_range(0, 1));
          case ($urandom_range(0, 7))
            0:       per = PeriodW'($urandom_range(0, 1));
            1:       per = PeriodW'($urandom_range(1000, 65535));
            default: per = PeriodW'($urandom_range(2, 40));
          endcase
        end
      endcase
      apply_setting(mode, duty, dead, pwm, per);
      idle_on <= (ph != NumPhases - 1);
      for (int k = 0; k < PhaseItems; k++)
        send_item(1'($urandom_range(0, 9) != 0), 1'($urandom_range(0, 19) == 0),
                  1'b0, NoRes);
    end

    // wind down
    wait_drained();
    repeat (4) @(posedge clk_i);
    if (pending_drive_q.size() != 0) begin
      n_bad += pending_drive_q.size();
      $display("%0d expected results never arrived", pending_drive_q.size());
    end
    $display("covered %0d transactions over %0d register settings plus directed corners",
             n_in, n_settings);
    $display("fixed sides, dead zone and duty saturation, zero half period;");
    $display("  %0d results checked, %0d errors", n_checked, n_bad);
    if (n_bad == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // run limit
  initial begin
    #(TimeoutNs);
    $display("timeout with %0d results outstanding", pending_drive_q.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
